// ===== rtl/core/ttq_pkg.sv =====
package ttq_pkg;

   typedef enum logic [2:0] {
      REQ_ENQUEUE       = 3'd0,
      REQ_ARM           = 3'd1,
      REQ_CANCEL_ALL    = 3'd2,
      REQ_CANCEL_HND    = 3'd3,
      REQ_CANCEL_HNDARG = 3'd4,
      REQ_CANCEL_OBJHND = 3'd5,
      REQ_TICK          = 3'd6,
      REQ_POP           = 3'd7
   } req_code_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] delay_ticks;
      logic [31:0] object_handle;
      logic [31:0] handler_handle;
      logic [31:0] arg_first;
      logic [31:0] arg_second;
      logic [31:0] arg_third;
   } req_payload_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] out_object;
      logic [31:0] out_handler;
      logic [31:0] out_arg_first;
      logic [31:0] out_arg_second;
      logic [31:0] out_arg_third;
      logic        queue_overflow;
      logic        table_full;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] obj;
      logic [31:0] hnd;
      logic [31:0] a0;
      logic [31:0] a1;
      logic [31:0] a2;
   } record_type;

   // token handed along the chain of slot cells, one cell per cycle
   typedef struct packed {
      logic         active;
      req_code_type op;
      logic [31:0]  delay;
      record_type   rec;
      logic         claimed;
   } token_type;

   // expiry report from a cell to the fifo writer
   typedef struct packed {
      logic       fire;
      record_type rec;
   } expire_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/core/ttq_cell.sv =====
module ttq_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               sel,
   input  ttq_pkg::token_type tok_i,
   output ttq_pkg::token_type tok_o,
   output ttq_pkg::expire_type exp_o
);
   import ttq_pkg::*;

   logic [31:0] count_ff, count_in;
   record_type  rec_ff, rec_in;
   logic        hit;
   logic [31:0] dec;

   assign dec = count_ff - 32'd1;

   always_comb begin
      count_in = count_ff;
      rec_in   = rec_ff;
      tok_o    = tok_i;
      exp_o    = '0;
      hit      = 1'b0;
      if (sel && tok_i.active) begin
         case (tok_i.op)
            REQ_ARM: begin
               if (!tok_i.claimed && count_ff == 32'd0) begin
                  count_in      = tok_i.delay;
                  rec_in        = tok_i.rec;
                  tok_o.claimed = 1'b1;
               end
            end
            REQ_CANCEL_ALL: hit = 1'b1;
            REQ_CANCEL_HND: hit = rec_ff.hnd == tok_i.rec.hnd;
            REQ_CANCEL_HNDARG:
               hit = rec_ff.hnd == tok_i.rec.hnd && rec_ff.a0 == {24'd0, tok_i.rec.a0[7:0]};
            REQ_CANCEL_OBJHND:
               hit = rec_ff.obj == tok_i.rec.obj && rec_ff.hnd == tok_i.rec.hnd;
            REQ_TICK: begin
               if (count_ff != 32'd0) begin
                  count_in = dec;
                  if (dec == 32'd0) begin
                     exp_o.fire = 1'b1;
                     exp_o.rec  = rec_ff;
                  end
               end
            end
            default: ;
         endcase
         if (hit && count_ff != 32'd0) count_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rec_ff <= rec_in;
   end

endmodule

// ===== rtl/core/ttq_fifo.sv =====
module ttq_fifo #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  ttq_pkg::record_type  wr_rec,
   input  logic                 rd_en,
   output logic                 rd_hit,
   output ttq_pkg::record_type  rd_rec,
   output logic                 overflow
);
   import ttq_pkg::*;

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   record_type      mem [FIFO_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic            ovf_ff, ovf_in;
   logic            hit_ff;
   record_type      data_ff;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      nxt = (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      ovf_in = ovf_ff;
      if (wr_en && wr_rec.hnd != 32'd0) begin
         wr_in = nxt(wr_ff);
         if (wr_in == rd_ff) ovf_in = 1'b1;
      end
      if (rd_en && rd_ff != wr_ff) rd_in = nxt(rd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         ovf_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         ovf_ff <= ovf_in;
         hit_ff <= rd_en && rd_ff != wr_ff;
      end
      if (wr_en && wr_rec.hnd != 32'd0) mem[wr_ff] <= wr_rec;
      data_ff <= mem[rd_ff];
   end

   assign rd_hit   = hit_ff;
   assign rd_rec   = data_ff;
   assign overflow = ovf_ff;

endmodule

// ===== rtl/core/timeout_table_event_queue_unit.sv =====
// timeout table with event fifo
// req channel: one request per transfer (enqueue, arm, four cancels, tick, pop)
// rsp channel: exactly one response per request, carrying the popped record
//   when a pop found the fifo nonempty, plus the sticky overflow and
//   table-full flags as they stand after the request
// one request at a time; req_stall is high from acceptance until the
//   response transfer
// enqueue and pop go from idle straight to the response state
// arm, cancel and tick walk the slot chain one cell per cycle, then go
//   to the response state; rsp_valid is registered there in each case
// the walk is set by the chain of slot cells, each cell visited once
// a new request is taken the cycle after the response transfer; each
//   rsp_stall cycle holds the response and so delays the next request
// expiries during a tick enter the fifo in slot order, one per cycle
// reset (synchronous) clears all counts, fifo indexes and both flags;
//   record storage is left as is
// rsp payload is held in a register and stays stable while rsp_stall is
//   high; no new request is taken until the response transfer completes
module timeout_table_event_queue_unit #(
   parameter int FIFO_DEPTH = 16,
   parameter int SLOT_COUNT = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ttq_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ttq_pkg::rsp_payload_type  rsp_payload
);
   import ttq_pkg::*;

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   state_type       state_ff, state_in;
   logic [SW-1:0]   idx_ff, idx_in;
   token_type       tok_ff, tok_in;
   logic            full_ff, full_in;
   logic            pop_ff;           // request was a pop, waiting for fifo read data
   rsp_payload_type rsp_ff, rsp_in;

   token_type  tok_chain [SLOT_COUNT+1];
   expire_type exp_v     [SLOT_COUNT];

   logic       fifo_wr;
   record_type fifo_wrec;
   logic       fifo_rd;
   logic       rd_hit;
   record_type rd_rec;
   logic       overflow;
   logic       accept;
   logic       walk_done;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign walk_done = idx_ff == SW'(SLOT_COUNT - 1);

   // the token runs through every cell, but only cell idx_ff acts on it in ST_WALK; others pass it unchanged
   assign tok_chain[0] = tok_ff;
   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      ttq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .sel   (idx_ff == SW'(g) && state_ff == ST_WALK),
         .tok_i (tok_chain[g]),
         .tok_o (tok_chain[g+1]),
         .exp_o (exp_v[g])
      );
   end

   // only the selected cell can report an expiry
   always_comb begin
      fifo_wr   = 1'b0;
      fifo_wrec = '0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (exp_v[k].fire) begin
            fifo_wr   = 1'b1;
            fifo_wrec = exp_v[k].rec;
         end
      end
      if (accept && req_payload.req_type == REQ_ENQUEUE) begin
         fifo_wr   = 1'b1;
         fifo_wrec = '{req_payload.object_handle, req_payload.handler_handle,
                       req_payload.arg_first, req_payload.arg_second,
                       req_payload.arg_third};
      end
   end

   assign fifo_rd = accept && req_payload.req_type == REQ_POP;

   ttq_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fifo_wr),
      .wr_rec   (fifo_wrec),
      .rd_en    (fifo_rd),
      .rd_hit   (rd_hit),
      .rd_rec   (rd_rec),
      .overflow (overflow)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.req_type == REQ_ENQUEUE || req_payload.req_type == REQ_POP)
                  state_in = ST_RESP;
               else
                  state_in = ST_WALK;
            end
         end
         ST_WALK: if (walk_done) state_in = ST_RESP;
         ST_RESP: if (rsp_valid && !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in  = idx_ff;
      tok_in  = tok_ff;
      full_in = full_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in         = '0;
            tok_in.active  = accept;
            tok_in.op      = req_code_type'(req_payload.req_type);
            tok_in.delay   = req_payload.delay_ticks;
            tok_in.rec     = '{req_payload.object_handle, req_payload.handler_handle,
                               req_payload.arg_first, req_payload.arg_second,
                               req_payload.arg_third};
            tok_in.claimed = 1'b0;
         end
         ST_WALK: begin
            tok_in = tok_chain[SLOT_COUNT];
            if (walk_done) begin
               tok_in.active = 1'b0;
               if (tok_ff.op == REQ_ARM && !tok_chain[SLOT_COUNT].claimed)
                  full_in = 1'b1;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         default: ;
      endcase
   end

   // response register: loaded on entry to ST_RESP while rsp_valid is low, once fifo data and flags have settled
   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == ST_RESP && !rsp_valid) begin
         rsp_in = '0;
         if (pop_ff && rd_hit) begin
            rsp_in.entry_valid    = 1'b1;
            rsp_in.out_object     = rd_rec.obj;
            rsp_in.out_handler    = rd_rec.hnd;
            rsp_in.out_arg_first  = rd_rec.a0;
            rsp_in.out_arg_second = rd_rec.a1;
            rsp_in.out_arg_third  = rd_rec.a2;
         end
         rsp_in.queue_overflow = overflow;
         rsp_in.table_full     = full_ff;
      end
   end

   logic rv_ff, rv_in;
   always_comb begin
      rv_in = rv_ff;
      if (state_ff == ST_RESP && !rv_ff) rv_in = 1'b1;
      else if (rv_ff && !rsp_stall) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         tok_ff.active <= 1'b0;
         full_ff       <= 1'b0;
         rv_ff         <= 1'b0;
         pop_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         tok_ff.active <= tok_in.active;
         full_ff       <= full_in;
         rv_ff         <= rv_in;
         if (accept) pop_ff <= req_payload.req_type == REQ_POP;
      end
      tok_ff.op      <= tok_in.op;
      tok_ff.delay   <= tok_in.delay;
      tok_ff.rec     <= tok_in.rec;
      tok_ff.claimed <= tok_in.claimed;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_only_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_RESP)
      else $error("response outside response state");
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(full_ff) |-> full_ff)
      else $error("table full flag cleared");
   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> idx_ff <= SW'(SLOT_COUNT - 1))
      else $error("walk index past last slot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept)
      else $error("request taken while busy");

endmodule

// ===== sim/tb_timeout_table_event_queue_unit.sv =====
module tb_timeout_table_event_queue_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ttq_pkg::*;

   localparam int QDEPTH = 16;
   localparam int NSLOTS = 8;
   localparam int RANDOM_ITEMS = 1500;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   timeout_table_event_queue_unit #(
      .FIFO_DEPTH(QDEPTH),
      .SLOT_COUNT(NSLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // scheduler shadow state
   record_type  ring_mem [QDEPTH];
   logic [3:0]  wr_ptr;
   logic [3:0]  rd_ptr;
   logic [31:0] countdown [NSLOTS];
   record_type  armed_rec [NSLOTS];
   logic        ovf_sticky;
   logic        full_sticky;

   // responses still owed by the dut, oldest first
   rsp_payload_type pending_rsp [$];
   int  error_count;
   // pool of handlers so cancels actually hit armed slots
   logic [31:0] hnd_pool [4];
   logic [31:0] obj_pool [2];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   function automatic void ring_push(input record_type r);
      if (r.hnd == 32'd0) begin
         return;
      end
      ring_mem[wr_ptr] = r;
      wr_ptr = wr_ptr + 4'd1;
      if (wr_ptr == rd_ptr) begin
         ovf_sticky = 1'b1;
      end
   endfunction

   function automatic rsp_payload_type schedule_step(input req_payload_type p);
      rsp_payload_type o;
      record_type      r;
      bit              hit;
      bit              placed;
      o = '0;
      r.obj = p.object_handle;
      r.hnd = p.handler_handle;
      r.a0  = p.arg_first;
      r.a1  = p.arg_second;
      r.a2  = p.arg_third;
      case (req_code_type'(p.req_type))
         REQ_ENQUEUE: ring_push(r);
         REQ_ARM: begin
            placed = 1'b0;
            for (int n = 0; n < NSLOTS && !placed; n++) begin
               if (countdown[n] == 32'd0) begin
                  countdown[n] = p.delay_ticks;
                  armed_rec[n] = r;
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               full_sticky = 1'b1;
            end
         end
         REQ_TICK: begin
            for (int n = 0; n < NSLOTS; n++) begin
               if (countdown[n] != 32'd0) begin
                  countdown[n] = countdown[n] - 32'd1;
                  if (countdown[n] == 32'd0) begin
                     ring_push(armed_rec[n]);
                  end
               end
            end
         end
         REQ_POP: begin
            if (rd_ptr != wr_ptr) begin
               o.entry_valid    = 1'b1;
               o.out_object     = ring_mem[rd_ptr].obj;
               o.out_handler    = ring_mem[rd_ptr].hnd;
               o.out_arg_first  = ring_mem[rd_ptr].a0;
               o.out_arg_second = ring_mem[rd_ptr].a1;
               o.out_arg_third  = ring_mem[rd_ptr].a2;
               rd_ptr = rd_ptr + 4'd1;
            end
         end
         default: begin
            // the four cancel flavors
            for (int n = 0; n < NSLOTS; n++) begin
               if (countdown[n] != 32'd0) begin
                  case (req_code_type'(p.req_type))
                     REQ_CANCEL_ALL: hit = 1'b1;
                     REQ_CANCEL_HND: hit = armed_rec[n].hnd == p.handler_handle;
                     // match argument is only 8 bits wide
                     REQ_CANCEL_HNDARG:
                        hit = armed_rec[n].hnd == p.handler_handle &&
                              armed_rec[n].a0 == {24'd0, p.arg_first[7:0]};
                     default:
                        hit = armed_rec[n].obj == p.object_handle &&
                              armed_rec[n].hnd == p.handler_handle;
                  endcase
                  if (hit) begin
                     countdown[n] = 32'd0;
                  end
               end
            end
         end
      endcase
      o.queue_overflow = ovf_sticky;
      o.table_full     = full_sticky;
      return o;
   endfunction

   // one transfer on the request side, after a gap set by the caller
   // valid drops at the accepting edge, and the next call waits out its gap before raising it again
   task automatic send_req(input req_payload_type p, input int gap);
      repeat (gap + 1) @(posedge clock);
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(schedule_step(p));
      req_valid <= 1'b0;
   endtask

   function automatic req_payload_type make_req(input req_code_type op,
         input logic [31:0] dly, input logic [31:0] obj, input logic [31:0] hnd,
         input logic [31:0] a0, input logic [31:0] a1, input logic [31:0] a2);
      req_payload_type p;
      p.req_type       = op;
      p.delay_ticks    = dly;
      p.object_handle  = obj;
      p.handler_handle = hnd;
      p.arg_first      = a0;
      p.arg_second     = a1;
      p.arg_third      = a2;
      return p;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type random_req();
      req_payload_type p;
      int              pick;
      pick = $urandom_range(0, 99);
      p.object_handle  = $urandom_range(0, 3) == 0 ? rand_word() :
                         obj_pool[$urandom_range(0, 1)];
      p.handler_handle = $urandom_range(0, 4) == 0 ? rand_word() :
                         hnd_pool[$urandom_range(0, 3)];
      p.arg_first      = $urandom_range(0, 1) ? $urandom_range(0, 3) : rand_word();
      p.arg_second     = rand_word();
      p.arg_third      = rand_word();
      // mostly short delays so timeouts really expire
      p.delay_ticks    = $urandom_range(0, 9) == 0 ? rand_word() : $urandom_range(0, 6);
      if (pick < 15) begin
         p.req_type = REQ_ENQUEUE;
      end else if (pick < 38) begin
         p.req_type = REQ_ARM;
      end else if (pick < 40) begin
         p.req_type = REQ_CANCEL_ALL;
      end else if (pick < 44) begin
         p.req_type = REQ_CANCEL_HND;
      end else if (pick < 48) begin
         p.req_type = REQ_CANCEL_HNDARG;
      end else if (pick < 52) begin
         p.req_type = REQ_CANCEL_OBJHND;
      end else if (pick < 75) begin
         p.req_type = REQ_TICK;
      end else begin
         p.req_type = REQ_POP;
      end
      return p;
   endfunction

   // response checker with random stall
   initial begin
      rsp_payload_type want;
      int              hold;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $realtime, rsp_payload);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.entry_valid !== want.entry_valid) begin
               $display("%0t: entry_valid expected %h actual %h", $realtime,
                        want.entry_valid, rsp_payload.entry_valid);
               error_count++;
            end
            if (rsp_payload.out_object !== want.out_object) begin
               $display("%0t: out_object expected %h actual %h", $realtime,
                        want.out_object, rsp_payload.out_object);
               error_count++;
            end
            if (rsp_payload.out_handler !== want.out_handler) begin
               $display("%0t: out_handler expected %h actual %h", $realtime,
                        want.out_handler, rsp_payload.out_handler);
               error_count++;
            end
            if (rsp_payload.out_arg_first !== want.out_arg_first) begin
               $display("%0t: out_arg_first expected %h actual %h", $realtime,
                        want.out_arg_first, rsp_payload.out_arg_first);
               error_count++;
            end
            if (rsp_payload.out_arg_second !== want.out_arg_second) begin
               $display("%0t: out_arg_second expected %h actual %h", $realtime,
                        want.out_arg_second, rsp_payload.out_arg_second);
               error_count++;
            end
            if (rsp_payload.out_arg_third !== want.out_arg_third) begin
               $display("%0t: out_arg_third expected %h actual %h", $realtime,
                        want.out_arg_third, rsp_payload.out_arg_third);
               error_count++;
            end
            if (rsp_payload.queue_overflow !== want.queue_overflow) begin
               $display("%0t: queue_overflow expected %h actual %h", $realtime,
                        want.queue_overflow, rsp_payload.queue_overflow);
               error_count++;
            end
            if (rsp_payload.table_full !== want.table_full) begin
               $display("%0t: table_full expected %h actual %h", $realtime,
                        want.table_full, rsp_payload.table_full);
               error_count++;
            end
         end
      end
   end

   // directed table: request plus, where obvious, the typed-in response
   typedef struct {
      req_payload_type req;
      bit              has_fixed;
      rsp_payload_type fixed;
   } directed_row_type;

   initial begin
      directed_row_type rows [$];
      directed_row_type row;
      rsp_payload_type  got;
      int               gap;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      error_count = 0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      ovf_sticky  = 1'b0;
      full_sticky = 1'b0;
      for (int n = 0; n < NSLOTS; n++) begin
         countdown[n] = '0;
         armed_rec[n] = '0;
      end
      for (int n = 0; n < 4; n++) hnd_pool[n] = $urandom | 32'd1;
      obj_pool[0] = 32'd0;
      obj_pool[1] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pop on empty fifo right after reset: all zero
      row.req = make_req(REQ_POP, '1, '1, '1, '1, '1, '1);
      row.has_fixed = 1; row.fixed = '0; rows.push_back(row);
      // zero handler on enqueue is ignored
      row.req = make_req(REQ_ENQUEUE, 0, 32'h1, 32'h0, 1, 2, 3);
      row.has_fixed = 1; row.fixed = '0; rows.push_back(row);
      row.req = make_req(REQ_POP, 0, 0, 0, 0, 0, 0);
      row.has_fixed = 1; row.fixed = '0; rows.push_back(row);
      // all-ones record enqueue then pop
      row.req = make_req(REQ_ENQUEUE, '1, '1, '1, '1, '1, '1);
      row.has_fixed = 1; row.fixed = '0; rows.push_back(row);
      row.req = make_req(REQ_POP, 0, 0, 0, 0, 0, 0);
      row.has_fixed = 1;
      row.fixed = {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0};
      rows.push_back(row);
      row.has_fixed = 0;
      // zero delay arm leaves slot free, zero handler arm fires nothing
      row.req = make_req(REQ_ARM, 0, 5, 6, 7, 8, 9); rows.push_back(row);
      row.req = make_req(REQ_ARM, 1, 5, 0, 7, 8, 9); rows.push_back(row);
      row.req = make_req(REQ_ARM, 2, 0, 32'h77, 32'h1AB, 8, 9); rows.push_back(row);
      row.req = make_req(REQ_ARM, '1, 3, 32'h88, 32'h12, 1, 1); rows.push_back(row);
      row.req = make_req(REQ_ARM, 3, 4, 32'h99, 0, 1, 1); rows.push_back(row);
      // handler+arg cancel uses low 8 bits of the match argument
      row.req = make_req(REQ_CANCEL_HNDARG, 0, 0, 32'h88, 32'hFFFF_FF12, 0, 0);
      rows.push_back(row);
      row.req = make_req(REQ_CANCEL_OBJHND, 0, 4, 32'h99, 0, 0, 0); rows.push_back(row);
      row.req = make_req(REQ_CANCEL_HND, 0, 0, 32'h12345, 0, 0, 0); rows.push_back(row);
      row.req = make_req(REQ_TICK, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.req = make_req(REQ_TICK, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      row.req = make_req(REQ_POP, 0, 0, 0, 0, 0, 0); rows.push_back(row);
      // fill every slot and one more: table full
      for (int n = 0; n < NSLOTS + 1; n++) begin
         row.req = make_req(REQ_ARM, 32'd50, 0, 32'h55, n, 0, 0); rows.push_back(row);
      end
      row.req = make_req(REQ_CANCEL_ALL, 0, 0, 0, 0, 0, 0); rows.push_back(row);

      foreach (rows[i]) begin
         send_req(rows[i].req, $urandom_range(0, 2));
         if (rows[i].has_fixed) begin
            got = pending_rsp[pending_rsp.size() - 1];
            if (got !== rows[i].fixed) begin
               $display("%0t: row %0d expected %h actual %h", $realtime, i,
                        rows[i].fixed, got);
               error_count++;
            end
         end
      end

      // overflow: QDEPTH + 2 enqueues make the ring wrap onto itself
      for (int n = 0; n < QDEPTH + 2; n++) begin
         send_req(make_req(REQ_ENQUEUE, 0, n, n + 1, n, n, n), 0);
      end
      // hold off until everything drained
      while (pending_rsp.size() != 0) @(posedge clock);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // bursts without gaps every so often
         gap = (k % 200 < 40) ? 0 : $urandom_range(0, 8);
         send_req(random_req(), gap);
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NSLOTS + 20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/ttq_pkg.sv
rtl/core/ttq_cell.sv
rtl/core/ttq_fifo.sv
rtl/core/timeout_table_event_queue_unit.sv
sim/tb_timeout_table_event_queue_unit.sv
